// File: design/sha1_pkg.sv
// shared types, codes and constants of the sha-1 stream hash
`timescale 1ns / 1ps

package sha1_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned Rounds    = 80;

  // initial chaining words, index 0 is h0
  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // byte sources for block insertion
  localparam logic [2:0] SRC_DATA = 3'd0;
  localparam logic [2:0] SRC_PAD  = 3'd1;
  localparam logic [2:0] SRC_ZERO = 3'd2;
  localparam logic [2:0] SRC_LENH = 3'd3;
  localparam logic [2:0] SRC_LENL = 3'd4;

  typedef struct packed {
    logic       load;
    logic       ins;
    logic [2:0] src;
    logic       rnd;
    logic [1:0] stage;
    logic       fold;
    logic       clear;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic pend_done;
    logic eom;
    logic at_56;
  } dp_stat_t;

  function automatic logic [31:0] round_k(input logic [1:0] stage);
    logic [31:0] k;
    case (stage)
      2'd0:    k = 32'h5A827999;
      2'd1:    k = 32'h6ED9EBA1;
      2'd2:    k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

// File: design/sha1_dp.sv
// sha-1 datapath: block buffer, schedule, round logic, chaining words and length
`timescale 1ns / 1ps

module sha1_dp import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [31:0] in_word,
  input  logic [2:0]  in_count,
  input  logic        in_eom,
  output dp_stat_t    stat,
  output logic [31:0] digest_word
);

  logic [BlockBits-1:0] block_r, block_nxt;
  logic [5:0]           fill_r, fill_nxt;
  logic [63:0]          len_r, len_nxt;
  logic [4:0][31:0]     chain_r, chain_nxt;
  logic [31:0]          pend_data_r, pend_data_nxt;
  logic [2:0]           pend_cnt_r, pend_cnt_nxt;
  logic                 eom_r, eom_nxt;
  logic [31:0]          va_r, vb_r, vc_r, vd_r, ve_r;

  logic [6:0]  room, want, lim, sum;
  logic [2:0]  k;
  logic [31:0] src_word, w, new_w, f, t, wx;
  logic [2:0]  cnt_clamp;
  logic        do_init;

  always_comb begin
    room = 7'd64 - {1'b0, fill_r};
    lim  = (fill_r < 6'd56) ? (7'd56 - {1'b0, fill_r}) : room;
    case (cmd.src)
      SRC_DATA: begin
        src_word = pend_data_r;
        want     = {4'b0, pend_cnt_r};
      end
      SRC_PAD: begin
        src_word = 32'h8000_0000;
        want     = 7'd1;
      end
      SRC_ZERO: begin
        src_word = 32'h0;
        want     = (lim < 7'd4) ? lim : 7'd4;
      end
      SRC_LENH: begin
        src_word = len_r[63:32];
        want     = 7'd4;
      end
      SRC_LENL: begin
        src_word = len_r[31:0];
        want     = 7'd4;
      end
      default: begin
        src_word = 32'h0;
        want     = 7'd0;
      end
    endcase
    k   = (want < room) ? want[2:0] : room[2:0];
    sum = {1'b0, fill_r} + {4'b0, k};
  end

  assign stat.full      = sum[6];
  assign stat.pend_done = (pend_cnt_r == 3'd0);
  assign stat.eom       = eom_r;
  assign stat.at_56     = (fill_r == 6'd56);

  assign do_init   = cmd.ins && sum[6];
  assign cnt_clamp = (in_count > 3'd4) ? 3'd4 : in_count;

  // schedule taps: word j of the window sits at block_r[511-32j -: 32]
  assign w     = block_r[511:480];
  assign wx    = block_r[95:64] ^ block_r[255:224] ^ block_r[447:416] ^ w;
  assign new_w = {wx[30:0], wx[31]};

  always_comb begin
    case (cmd.stage)
      2'd0:    f = (vb_r & vc_r) | (~vb_r & vd_r);
      2'd2:    f = (vb_r & vc_r) | (vb_r & vd_r) | (vc_r & vd_r);
      default: f = vb_r ^ vc_r ^ vd_r;
    endcase
    t = {va_r[26:0], va_r[31:27]} + f + ve_r + round_k(cmd.stage) + w;
  end

  always_comb begin
    block_nxt     = block_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    chain_nxt     = chain_r;
    pend_data_nxt = pend_data_r;
    pend_cnt_nxt  = pend_cnt_r;
    eom_nxt       = eom_r;
    if (cmd.load) begin
      pend_data_nxt = in_word;
      pend_cnt_nxt  = cnt_clamp;
      eom_nxt       = in_eom;
    end
    if (cmd.ins) begin
      case (k)
        3'd1:    block_nxt = {block_r[503:0], src_word[31:24]};
        3'd2:    block_nxt = {block_r[495:0], src_word[31:16]};
        3'd3:    block_nxt = {block_r[487:0], src_word[31:8]};
        3'd4:    block_nxt = {block_r[479:0], src_word};
        default: block_nxt = block_r;
      endcase
      fill_nxt = sum[5:0];
      if (cmd.src == SRC_DATA) begin
        pend_cnt_nxt = pend_cnt_r - k;
        len_nxt      = len_r + {58'b0, k, 3'b0};
        case (k)
          3'd1:    pend_data_nxt = {pend_data_r[23:0], 8'h0};
          3'd2:    pend_data_nxt = {pend_data_r[15:0], 16'h0};
          3'd3:    pend_data_nxt = {pend_data_r[7:0], 24'h0};
          3'd4:    pend_data_nxt = 32'h0;
          default: pend_data_nxt = pend_data_r;
        endcase
      end
    end
    if (cmd.rnd) begin
      block_nxt = {block_r[479:0], new_w};
    end
    if (cmd.fold) begin
      chain_nxt[0] = chain_r[0] + va_r;
      chain_nxt[1] = chain_r[1] + vb_r;
      chain_nxt[2] = chain_r[2] + vc_r;
      chain_nxt[3] = chain_r[3] + vd_r;
      chain_nxt[4] = chain_r[4] + ve_r;
    end
    if (cmd.clear) begin
      chain_nxt = SHA1_IV;
      fill_nxt  = 6'd0;
      len_nxt   = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 6'd0;
      len_r      <= 64'd0;
      chain_r    <= SHA1_IV;
      pend_cnt_r <= 3'd0;
      eom_r      <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      len_r      <= len_nxt;
      chain_r    <= chain_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      eom_r      <= eom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    block_r     <= block_nxt;
    pend_data_r <= pend_data_nxt;
    if (do_init) begin
      va_r <= chain_r[0];
      vb_r <= chain_r[1];
      vc_r <= chain_r[2];
      vd_r <= chain_r[3];
      ve_r <= chain_r[4];
    end else if (cmd.rnd) begin
      ve_r <= vd_r;
      vd_r <= vc_r;
      vc_r <= {vb_r[1:0], vb_r[31:2]};
      vb_r <= va_r;
      va_r <= t;
    end
  end

  assign digest_word = chain_r[cmd.out_idx];

endmodule

// File: design/sha1_ctrl.sv
// sha-1 controller: sequencing of fill, padding, rounds and digest output
`timescale 1ns / 1ps

module sha1_ctrl import sha1_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DATA  = 4'd1;
  localparam logic [3:0] S_PAD   = 4'd2;
  localparam logic [3:0] S_ZERO  = 4'd3;
  localparam logic [3:0] S_LENH  = 4'd4;
  localparam logic [3:0] S_LENL  = 4'd5;
  localparam logic [3:0] S_ROUND = 4'd6;
  localparam logic [3:0] S_FOLD  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [6:0] LastRound = 7'(Rounds - 1);

  logic [3:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd.load    = in_ready && in_valid;
    cmd.ins     = 1'b0;
    cmd.src     = SRC_DATA;
    cmd.rnd     = (state_r == S_ROUND);
    cmd.fold    = (state_r == S_FOLD);
    cmd.clear   = out_valid && out_ready && (idx_r == 3'd4);
    cmd.out_idx = idx_r;
    if (rnd_r < 7'd20) begin
      cmd.stage = 2'd0;
    end else if (rnd_r < 7'd40) begin
      cmd.stage = 2'd1;
    end else if (rnd_r < 7'd60) begin
      cmd.stage = 2'd2;
    end else begin
      cmd.stage = 2'd3;
    end
    case (state_r)
      S_DATA: begin
        cmd.ins = 1'b1;
        cmd.src = SRC_DATA;
      end
      S_PAD: begin
        cmd.ins = 1'b1;
        cmd.src = SRC_PAD;
      end
      S_ZERO: begin
        cmd.ins = !stat.at_56;
        cmd.src = SRC_ZERO;
      end
      S_LENH: begin
        cmd.ins = 1'b1;
        cmd.src = SRC_LENH;
      end
      S_LENL: begin
        cmd.ins = 1'b1;
        cmd.src = SRC_LENL;
      end
      default: begin
        cmd.ins = 1'b0;
        cmd.src = SRC_DATA;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DATA;
      end
      S_DATA: begin
        if (stat.pend_done) begin
          state_nxt = stat.eom ? S_PAD : S_IDLE;
        end else if (stat.full) begin
          state_nxt = S_ROUND;
          ret_nxt   = S_DATA;
        end
      end
      S_PAD: begin
        state_nxt = stat.full ? S_ROUND : S_ZERO;
        ret_nxt   = S_ZERO;
      end
      S_ZERO: begin
        if (stat.at_56) begin
          state_nxt = S_LENH;
        end else if (stat.full) begin
          state_nxt = S_ROUND;
          ret_nxt   = S_ZERO;
        end
      end
      S_LENH: state_nxt = S_LENL;
      S_LENL: begin
        state_nxt = S_ROUND;
        ret_nxt   = S_OUT;
      end
      S_ROUND: begin
        if (rnd_r == LastRound) begin
          rnd_nxt   = 7'd0;
          state_nxt = S_FOLD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      S_FOLD: state_nxt = ret_r;
      S_OUT: begin
        if (out_ready) begin
          if (idx_r == 3'd4) begin
            idx_nxt   = 3'd0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      rnd_r   <= 7'd0;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // round counter rests at zero outside the round loop
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_ROUND |-> rnd_r == 7'd0)
    else $error("round counter not at zero outside rounds");

  // fold moves on to the return phase saved when the compression started
  a_fold_ret: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FOLD |=> state_r == $past(ret_r))
    else $error("fold did not resume saved phase");

  // a full block always leads straight into the rounds
  a_full_round: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins && stat.full) |=> state_r == S_ROUND)
    else $error("full block not compressed");

  // digest output starts at word zero
  a_out_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_OUT) |-> idx_r == 3'd0)
    else $error("digest output not starting at word zero");

  // the digest is only shown after the length words went in
  a_out_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_OUT) |-> $past(state_r) == S_FOLD && $past(ret_r) == S_OUT)
    else $error("digest output entered from wrong phase");

endmodule

// File: design/sha1_stream_hash.sv
// top level of the streaming sha-1 engine
`timescale 1ns / 1ps

// SHA-1 over a stream of big-endian 32-bit words, 1 to 4 valid bytes each (counts above
// four count as four, a zero count adds nothing), bytes concatenating freely across words.
// in_tlast marks the final word; its bytes are taken, the message is padded with 0x80, zeros
// and the 64-bit bit length, and the five digest words h0..h4 come out with the index in
// tdata and tlast on h4, after which the engine is ready for the next message. Each 64-byte
// block runs through the 80 rounds of the single shared round unit and then the chaining
// add. The final word adds padding, one or two compressions and the digest output. Words
// are taken only while the engine is idle.
module sha1_stream_hash import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], bytes_valid[34:32], zeros
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zeros
  output logic        out_tlast
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] digest_word;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_word     (in_tdata[31:0]),
    .in_count    (in_tdata[34:32]),
    .in_eom      (in_tlast),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign out_tdata = {5'b0, cmd.out_idx, digest_word};
  assign out_tlast = (cmd.out_idx == 3'd4);

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the streaming sha-1 engine
`timescale 1ns / 1ps

module tb_top;
  import sha1_pkg::*;

  localparam int unsigned RandomWords = 400;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned LongHoldAt  = 60;
  localparam int unsigned LongHold    = 700;

  // h4 down to h0, so that index 0 is the first digest word
  localparam logic [4:0][31:0] EmptyDigest = {
    32'hAFD80709, 32'h95601890, 32'h3255BFEF, 32'h5E6B4B0D, 32'hDA39A3EE
  };
  localparam logic [4:0][31:0] AbcDigest = {
    32'h9CD0D89D, 32'h7850C26C, 32'hBA3E2571, 32'h4706816A, 32'hA9993E36
  };

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  typedef struct {
    logic [31:0]      word;
    logic [2:0]       nbytes;
    logic             eom;
    bit               typed;
    logic [4:0][31:0] dig;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // data_word[31:0], bytes_valid[34:32], zeros
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;      // digest_word[31:0], word_index[34:32], zeros
  logic        out_tlast;

  logic [31:0]  hash_h [5];
  logic [7:0]   blk_bytes [64];
  int unsigned  blk_fill;
  logic [63:0]  msg_bits;

  digest_word_t digest_q [$];
  digest_word_t want;
  stim_row_t    dir_rows [$];
  int unsigned  fail_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  words_sent = 0;
  int unsigned  recv_taken = 0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  sha1_stream_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    hash_h[0] = 32'h67452301;
    hash_h[1] = 32'hEFCDAB89;
    hash_h[2] = 32'h98BADCFE;
    hash_h[3] = 32'h10325476;
    hash_h[4] = 32'hC3D2E1F0;
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  function automatic void sha1_put_byte(input logic [7:0] value);
    blk_bytes[blk_fill] = value;
    blk_fill++;
    if (blk_fill == 64) begin
      sha1_compress();
      blk_fill = 0;
    end
  endfunction

  // returns 1 when the word closes a message, with the digest in dig
  function automatic bit sha1_absorb_word(input logic [31:0] word, input logic [2:0] nbytes,
                                          input logic eom, output logic [4:0][31:0] dig);
    int unsigned take;
    logic [63:0] len_bits;
    take = (nbytes > 3'd4) ? 4 : nbytes;
    dig = '0;
    for (int i = 0; i < take; i++) begin
      sha1_put_byte(word[31-8*i -: 8]);
      msg_bits += 64'd8;
    end
    if (!eom)
      return 1'b0;
    len_bits = msg_bits;
    sha1_put_byte(8'h80);
    while (blk_fill != 56)
      sha1_put_byte(8'h00);
    for (int i = 0; i < 8; i++)
      sha1_put_byte(len_bits[63-8*i -: 8]);
    for (int i = 0; i < 5; i++)
      dig[i] = hash_h[i];
    sha1_restart();
    return 1'b1;
  endfunction

  task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes, input logic eom,
                           input bit typed, input logic [4:0][31:0] typed_dig);
    int unsigned gap;
    logic [4:0][31:0] dig;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, nbytes, word};
    in_tlast  <= eom;
    do @(posedge clk); while (!in_tready);
    if (sha1_absorb_word(word, nbytes, eom, dig)) begin
      for (int i = 0; i < 5; i++)
        digest_q.push_back('{typed ? typed_dig[i] : dig[i], 3'(i), i == 4});
    end
    if (nbytes != 3'd0 || eom)
      words_sent++;
  endtask

  task automatic send_message(input int unsigned nwords);
    logic [2:0] nbytes;
    int unsigned pick;
    for (int w = 0; w < nwords; w++) begin
      pick = $urandom_range(0, 19);
      if (pick < 10)
        nbytes = 3'd4;
      else if (pick == 16)
        nbytes = 3'($urandom_range(5, 7));
      else if (pick == 17)
        nbytes = 3'd0;
      else
        nbytes = 3'($urandom_range(1, 3));
      send_word($urandom, nbytes, 1'b0, 1'b0, '0);
    end
    nbytes = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    send_word($urandom, nbytes, 1'b1, 1'b0, '0);
  endtask

  initial begin
    int unsigned msg_num;
    int unsigned pick;
    sha1_restart();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty message, abc, odd byte counts, ignored low bytes, 56-byte message
    dir_rows.push_back('{32'h0000_0000, 3'd0, 1'b1, 1'b1, EmptyDigest});
    dir_rows.push_back('{32'h6162_63FF, 3'd3, 1'b1, 1'b1, AbcDigest});
    dir_rows.push_back('{32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'h1234_5678, 3'd0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'hABFF_FFFF, 3'd1, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'h0000_0000, 3'd5, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'hCDEF_5A5A, 3'd2, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'hFFFF_FFFF, 3'd6, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'h0000_0000, 3'd4, 1'b1, 1'b0, '0});
    for (int i = 0; i < 14; i++)
      dir_rows.push_back('{(i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0, '0});

    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].nbytes, dir_rows[i].eom,
                dir_rows[i].typed, dir_rows[i].dig);
    words_sent = 0;

    msg_num = 0;
    while (words_sent < RandomWords) begin
      send_burst = ($urandom_range(0, 3) == 0);
      if (msg_num == 12) begin
        // hold off until the engine has drained
        in_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      pick = $urandom_range(0, 19);
      if (pick < 12)
        send_message($urandom_range(0, 8));
      else if (pick < 17)
        send_message($urandom_range(9, 20));
      else
        send_message($urandom_range(21, 48));
      msg_num++;
    end
    in_tvalid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int unsigned hold;
    while (!rst_n) @(posedge clk);
    forever begin
      if (recv_taken % 8 == 0)
        recv_burst = ($urandom_range(0, 3) == 0);
      if (recv_taken == LongHoldAt)
        hold = LongHold;
      else
        hold = recv_burst ? 0 : $urandom_range(0, 18);
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      recv_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word, expected none, got %h idx %0d last %0b",
                 $time, out_tdata[31:0], out_tdata[34:32], out_tlast);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (out_tdata[31:0] !== want.digest || out_tdata[34:32] !== want.index ||
            out_tlast !== want.last) begin
          $display({"%0t: digest word mismatch, expected %h idx %0d last %0b,",
                    " got %h idx %0d last %0b"},
                   $time, want.digest, want.index, want.last,
                   out_tdata[31:0], out_tdata[34:32], out_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// File: sim.f
design/sha1_pkg.sv
design/sha1_dp.sv
design/sha1_ctrl.sv
design/sha1_stream_hash.sv
tb/tb_top.sv
